@@ src/hds_pkg.sv @@
// Shared types and constants of the heat diffusion stencil block.
// Command and status structs between controller and datapath, register indexes.
// No dependencies.
package hds_pkg;

   // default geometry and number format
   localparam int DEF_MAX_ROWS   = 64;
   localparam int DEF_MAX_COLS   = 32;
   localparam int DEF_TEMP_WIDTH = 24;

   // field and register widths
   localparam int SRC_W      = 16;
   localparam int ROWS_CFG_W = 7;
   localparam int COLS_CFG_W = 6;
   localparam int GAIN_W     = 24;
   localparam int RAD_W      = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROWS  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RAD   = 3'd4;

   // register reset values
   localparam logic [ROWS_CFG_W-1:0] ROWS_RST  = 7'd50;
   localparam logic [COLS_CFG_W-1:0] COLS_RST  = 6'd25;
   localparam logic [GAIN_W-1:0]     GAIN_RST  = 24'd262843;
   localparam logic [GAIN_W-1:0]     SCALE_RST = 24'd111848;
   localparam logic [RAD_W-1:0]      RAD_RST   = 32'd933880;

   // radiation product is kept in three 32-bit limbs
   localparam logic [1:0] LIMB_TOP   = 2'd2;
   localparam logic [1:0] ROUND_LAST = 2'd3;

   // which stored cell a read fetches
   typedef enum logic [1:0] {
      RD_CENTER = 2'd0,
      RD_NORTH  = 2'd1,
      RD_WEST   = 2'd2,
      RD_EAST   = 2'd3
   } rd_sel_type;

   typedef struct packed {
      logic       accept;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       absorb_center;
      logic       absorb_nb;
      logic       mul_gain;
      logic       acc_gain;
      logic       mul_src;
      logic       acc_src;
      logic       cond_calc;
      logic       mul_limb;
      logic       add_limb;
      logic [1:0] limb_sel;
      logic       load_out;
      logic       next_k;
      logic       write_cell;
   } cmd_type;

   typedef struct packed {
      logic has_prev;
      logic is_last;
      logic flush_mode;
      logic flush_done;
      logic out_free;
   } status_type;

endpackage

@@ src/heat_diffusion_stencil_step.sv @@
// One explicit heat diffusion step over a streamed grid, with source and radiation loss.
// Cells enter row by row; each cell's new temperature leaves one row late, and
// the frame's last cell also flushes the final row. A cell that releases a result goes
// from acceptance to the next acceptance through: accept, a decode step, store reads
// (center, north, west, east, then absorbing the east read), multiply and accumulate
// steps, a saturation step, limb products for T^4 times the radiation coefficient on
// the one shared multiplier, the output load and the store write. A cell in the first
// row releases nothing and takes only accept, decode and store write. Every flushed
// cell repeats the steps from the store reads through the output load. The multiplier
// and the single store read port set this sequence; a result held by rsp_ready
// stretches the output load. A new cell is taken while a result still waits on rsp_.
// Depends on hds_pkg, hds_ctrl and hds_datapath.
module heat_diffusion_stencil_step import hds_pkg::*; #(
   parameter int MAX_ROWS   = DEF_MAX_ROWS,
   parameter int MAX_COLS   = DEF_MAX_COLS,
   parameter int TEMP_WIDTH = DEF_TEMP_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [TEMP_WIDTH-1:0]       req_cell_temp,
   input  logic                        req_is_material,
   input  logic [SRC_W-1:0]            req_heat_source,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [TEMP_WIDTH-1:0]       rsp_new_temp,
   output logic [$clog2(MAX_ROWS)-1:0] rsp_out_row,
   output logic [$clog2(MAX_COLS)-1:0] rsp_out_col,
   output logic                        rsp_frame_end
);

   cmd_type    cmd;
   status_type status;

   hds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hds_datapath #(
      .MAX_ROWS   (MAX_ROWS),
      .MAX_COLS   (MAX_COLS),
      .TEMP_WIDTH (TEMP_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .req_cell_temp   (req_cell_temp),
      .req_is_material (req_is_material),
      .req_heat_source (req_heat_source),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_new_temp    (rsp_new_temp),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_frame_end   (rsp_frame_end)
   );

endmodule

@@ src/hds_ctrl.sv @@
// Sequencer of the heat diffusion stencil block.
// Issues datapath commands per state; uses hds_pkg.
module hds_ctrl import hds_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_START    = 16'h0002,
      ST_RD_CTR   = 16'h0004,
      ST_RD_NORTH = 16'h0008,
      ST_RD_WEST  = 16'h0010,
      ST_RD_EAST  = 16'h0020,
      ST_ABS_EAST = 16'h0040,
      ST_MUL_G    = 16'h0080,
      ST_ACC_G    = 16'h0100,
      ST_MUL_S    = 16'h0200,
      ST_ACC_S    = 16'h0400,
      ST_COND     = 16'h0800,
      ST_MUL_L    = 16'h1000,
      ST_ADD_L    = 16'h2000,
      ST_OUT      = 16'h4000,
      ST_WRITE    = 16'h8000
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] limb_ff, limb_in;
   logic [1:0] round_ff, round_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         limb_ff  <= '0;
         round_ff <= '0;
      end else begin
         state_ff <= state_in;
         limb_ff  <= limb_in;
         round_ff <= round_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      limb_in      = limb_ff;
      round_in     = round_ff;
      cmd          = '0;
      cmd.limb_sel = limb_ff;
      req_ready    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_START;
            end
         end
         ST_START: begin
            state_in = status.has_prev ? ST_RD_CTR : ST_WRITE;
         end
         ST_RD_CTR: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CENTER;
            state_in   = ST_RD_NORTH;
         end
         ST_RD_NORTH: begin
            cmd.rd_en         = 1'b1;
            cmd.rd_sel        = RD_NORTH;
            cmd.absorb_center = 1'b1;
            state_in          = ST_RD_WEST;
         end
         ST_RD_WEST: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_WEST;
            cmd.absorb_nb = 1'b1;
            state_in      = ST_RD_EAST;
         end
         ST_RD_EAST: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = RD_EAST;
            cmd.absorb_nb = 1'b1;
            state_in      = ST_ABS_EAST;
         end
         ST_ABS_EAST: begin
            cmd.absorb_nb = 1'b1;
            state_in      = ST_MUL_G;
         end
         ST_MUL_G: begin
            cmd.mul_gain = 1'b1;
            state_in     = ST_ACC_G;
         end
         ST_ACC_G: begin
            cmd.acc_gain = 1'b1;
            state_in     = ST_MUL_S;
         end
         ST_MUL_S: begin
            cmd.mul_src = 1'b1;
            state_in    = ST_ACC_S;
         end
         ST_ACC_S: begin
            cmd.acc_src = 1'b1;
            state_in    = ST_COND;
         end
         ST_COND: begin
            cmd.cond_calc = 1'b1;
            limb_in       = '0;
            round_in      = '0;
            state_in      = ST_MUL_L;
         end
         ST_MUL_L: begin
            cmd.mul_limb = 1'b1;
            state_in     = ST_ADD_L;
         end
         ST_ADD_L: begin
            cmd.add_limb = 1'b1;
            state_in     = ST_MUL_L;
            if (limb_ff == LIMB_TOP) begin
               limb_in = '0;
               if (round_ff == ROUND_LAST) begin
                  state_in = ST_OUT;
               end else begin
                  round_in = round_ff + 2'd1;
               end
            end else begin
               limb_in = limb_ff + 2'd1;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (!status.flush_mode) begin
                  state_in = ST_WRITE;
               end else if (status.flush_done) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.next_k = 1'b1;
                  state_in   = ST_RD_CTR;
               end
            end
         end
         ST_WRITE: begin
            cmd.write_cell = 1'b1;
            state_in       = status.is_last ? ST_RD_CTR : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ src/hds_datapath.sv @@
// Datapath of the heat diffusion stencil block: registers, column store,
// shared multiplier, update arithmetic and output register. Uses hds_pkg.
module hds_datapath import hds_pkg::*; #(
   parameter int MAX_ROWS   = DEF_MAX_ROWS,
   parameter int MAX_COLS   = DEF_MAX_COLS,
   parameter int TEMP_WIDTH = DEF_TEMP_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wr_data,
   input  logic [TEMP_WIDTH-1:0]         req_cell_temp,
   input  logic                          req_is_material,
   input  logic [SRC_W-1:0]              req_heat_source,
   input  cmd_type                       cmd,
   output status_type                    status,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [TEMP_WIDTH-1:0]         rsp_new_temp,
   output logic [$clog2(MAX_ROWS)-1:0]   rsp_out_row,
   output logic [$clog2(MAX_COLS)-1:0]   rsp_out_col,
   output logic                          rsp_frame_end
);

   localparam int RIW   = $clog2(MAX_ROWS);
   localparam int CIW   = $clog2(MAX_COLS);
   localparam int DEPTH = 2 * MAX_COLS;
   localparam int MAW   = $clog2(DEPTH);
   localparam int ENT_W = TEMP_WIDTH + 1 + SRC_W;
   localparam int NS_W  = TEMP_WIDTH + 2;
   localparam int AW    = (NS_W > 32) ? NS_W : 32;
   localparam int PW    = AW + 32;
   localparam int SP_W  = SRC_W + GAIN_W;
   localparam int ACC_W = (TEMP_WIDTH + 28 > 51) ? TEMP_WIDTH + 28 : 51;
   localparam int TI_W  = TEMP_WIDTH - 8;
   localparam logic [TEMP_WIDTH-1:0] TEMP_MAX = {TEMP_WIDTH{1'b1}};
   localparam logic [ACC_W-1:0]      ROUND_HALF = ACC_W'(1) << 23;

   // configuration registers
   logic [ROWS_CFG_W-1:0] rows_cfg_ff;
   logic [COLS_CFG_W-1:0] cols_cfg_ff;
   logic [GAIN_W-1:0]     gain_ff, scale_ff;
   logic [RAD_W-1:0]      rad_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_cfg_ff <= ROWS_RST;
         cols_cfg_ff <= COLS_RST;
         gain_ff     <= GAIN_RST;
         scale_ff    <= SCALE_RST;
         rad_ff      <= RAD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_ROWS:  rows_cfg_ff <= csr_wr_data[ROWS_CFG_W-1:0];
            REG_COLS:  cols_cfg_ff <= csr_wr_data[COLS_CFG_W-1:0];
            REG_GAIN:  gain_ff     <= csr_wr_data[GAIN_W-1:0];
            REG_SCALE: scale_ff    <= csr_wr_data[GAIN_W-1:0];
            REG_RAD:   rad_ff      <= csr_wr_data[RAD_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // saturated geometry
   logic [RIW:0]   rows_sat;
   logic [CIW:0]   cols_sat;
   logic [RIW-1:0] rows_m1, r_now;
   logic [CIW-1:0] cols_m1, c_now;
   logic [RIW-1:0] row_cnt_ff;
   logic [CIW-1:0] col_cnt_ff;

   always_comb begin
      if (rows_cfg_ff == '0) begin
         rows_sat = (RIW+1)'(1);
      end else if (int'(rows_cfg_ff) > MAX_ROWS) begin
         rows_sat = (RIW+1)'(MAX_ROWS);
      end else begin
         rows_sat = (RIW+1)'(rows_cfg_ff);
      end
      if (cols_cfg_ff == '0) begin
         cols_sat = (CIW+1)'(1);
      end else if (int'(cols_cfg_ff) > MAX_COLS) begin
         cols_sat = (CIW+1)'(MAX_COLS);
      end else begin
         cols_sat = (CIW+1)'(cols_cfg_ff);
      end
      rows_m1 = RIW'(rows_sat - 1'b1);
      cols_m1 = CIW'(cols_sat - 1'b1);
      r_now   = ({1'b0, row_cnt_ff} < rows_sat) ? row_cnt_ff : rows_m1;
      c_now   = ({1'b0, col_cnt_ff} < cols_sat) ? col_cnt_ff : cols_m1;
   end

   // item and position registers
   logic [TEMP_WIDTH-1:0] cur_temp_ff;
   logic                  cur_mat_ff;
   logic [SRC_W-1:0]      cur_src_ff;
   logic [RIW-1:0]        r_ff;
   logic [CIW-1:0]        c_ff, k_ff, j;
   logic                  last_ff, flush_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cur_temp_ff <= req_cell_temp;
         cur_mat_ff  <= req_is_material;
         cur_src_ff  <= req_heat_source;
         r_ff        <= r_now;
         c_ff        <= c_now;
         last_ff     <= (r_now == rows_m1) && (c_now == cols_m1);
      end
   end

   // position counters and flush control
   always_ff @(posedge clock) begin
      if (reset) begin
         row_cnt_ff <= '0;
         col_cnt_ff <= '0;
         flush_ff   <= 1'b0;
         k_ff       <= '0;
      end else begin
         if (cmd.accept) begin
            flush_ff <= 1'b0;
         end
         if (cmd.next_k) begin
            k_ff <= k_ff + 1'b1;
         end
         if (cmd.write_cell) begin
            if (last_ff) begin
               row_cnt_ff <= '0;
               col_cnt_ff <= '0;
               flush_ff   <= 1'b1;
               k_ff       <= '0;
            end else if (c_ff == cols_m1) begin
               row_cnt_ff <= r_ff + 1'b1;
               col_cnt_ff <= '0;
            end else begin
               row_cnt_ff <= r_ff;
               col_cnt_ff <= c_ff + 1'b1;
            end
         end
      end
   end

   assign j = flush_ff ? k_ff : c_ff;

   // column store: two rows of cells, ping-ponged by row parity
   logic             par_cs, par_ps, rd_par, rd_pres, pres_ff;
   logic [CIW-1:0]   rd_idx, j_m1;
   logic [CIW:0]     j_p1;
   logic [MAW-1:0]   rd_addr, wr_addr;
   logic [ENT_W-1:0] mem [DEPTH];
   logic [ENT_W-1:0] rd_ff;

   assign par_cs = r_ff[0];
   assign par_ps = ~r_ff[0];
   assign j_m1   = j - 1'b1;
   assign j_p1   = {1'b0, j} + 1'b1;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_CENTER: begin
            rd_par  = flush_ff ? par_cs : par_ps;
            rd_idx  = j;
            rd_pres = 1'b1;
         end
         RD_NORTH: begin
            rd_par  = flush_ff ? par_ps : par_cs;
            rd_idx  = j;
            rd_pres = flush_ff ? (r_ff != '0) : (r_ff > RIW'(1));
         end
         RD_WEST: begin
            rd_par  = flush_ff ? par_cs : par_ps;
            rd_idx  = j_m1;
            rd_pres = (j != '0);
         end
         RD_EAST: begin
            rd_par  = flush_ff ? par_cs : par_ps;
            rd_idx  = j_p1[CIW-1:0];
            rd_pres = (j_p1 < cols_sat);
         end
         default: begin
            rd_par  = 1'b0;
            rd_idx  = j;
            rd_pres = 1'b0;
         end
      endcase
   end

   assign rd_addr = rd_par ? MAW'(MAX_COLS) + MAW'(rd_idx) : MAW'(rd_idx);
   assign wr_addr = par_cs ? MAW'(MAX_COLS) + MAW'(c_ff) : MAW'(c_ff);

   always_ff @(posedge clock) begin
      if (cmd.write_cell) begin
         mem[wr_addr] <= {cur_temp_ff, cur_mat_ff, cur_src_ff};
      end
      if (cmd.rd_en) begin
         rd_ff   <= mem[rd_addr];
         pres_ff <= rd_pres;
      end
   end

   logic [TEMP_WIDTH-1:0] rd_temp;
   logic                  rd_mat;
   logic [SRC_W-1:0]      rd_src;
   assign rd_temp = rd_ff[ENT_W-1 -: TEMP_WIDTH];
   assign rd_mat  = rd_ff[SRC_W];
   assign rd_src  = rd_ff[SRC_W-1:0];

   // neighbor sum; a missing or wall neighbor counts as the center
   logic [TEMP_WIDTH-1:0] ctr_temp_ff;
   logic [SRC_W-1:0]      ctr_src_ff;
   logic [NS_W-1:0]       nsum_ff;

   always_ff @(posedge clock) begin
      if (cmd.absorb_center) begin
         ctr_temp_ff <= rd_temp;
         ctr_src_ff  <= rd_src;
         nsum_ff     <= NS_W'((!flush_ff && cur_mat_ff) ? cur_temp_ff : rd_temp);
      end else if (cmd.absorb_nb) begin
         nsum_ff <= nsum_ff + NS_W'((pres_ff && rd_mat) ? rd_temp : ctr_temp_ff);
      end
   end

   // laplacian magnitude and sign
   logic signed [NS_W:0] diff;
   logic [NS_W-1:0]      mag;
   assign diff = $signed({1'b0, nsum_ff}) - $signed({1'b0, ctr_temp_ff, 2'b00});
   assign mag  = diff[NS_W] ? NS_W'(-diff) : NS_W'(diff);

   // shared multiplier
   logic [AW-1:0]   mul_a;
   logic [31:0]     mul_b;
   logic [PW-1:0]   mul_p, prod_ff;
   logic            neg_ff;
   logic [31:0]     l_ff [3];
   logic [TI_W-1:0] ti_ff;

   always_comb begin
      priority if (cmd.mul_gain) begin
         mul_a = AW'(mag);
         mul_b = 32'(gain_ff);
      end else if (cmd.mul_src) begin
         mul_a = AW'(ctr_src_ff);
         mul_b = 32'(scale_ff);
      end else begin
         mul_a = AW'(l_ff[cmd.limb_sel]);
         mul_b = 32'(ti_ff);
      end
   end

   assign mul_p = mul_a * mul_b;

   always_ff @(posedge clock) begin
      if (cmd.mul_gain || cmd.mul_src || cmd.mul_limb) begin
         prod_ff <= mul_p;
      end
      if (cmd.mul_gain) begin
         neg_ff <= diff[NS_W];
      end
   end

   // accumulator: gain term, source term and rounding half
   logic signed [ACC_W-1:0] acc_ff, acc_sh;
   logic        [ACC_W-1:0] src_term;
   assign src_term = ACC_W'({prod_ff[SP_W-1:0], 8'h00});

   always_ff @(posedge clock) begin
      if (cmd.acc_gain) begin
         acc_ff <= neg_ff ? -$signed(ACC_W'(prod_ff)) : $signed(ACC_W'(prod_ff));
      end else if (cmd.acc_src) begin
         acc_ff <= acc_ff + $signed(src_term) + $signed(ROUND_HALF);
      end
   end

   // conducted temperature, saturated
   logic signed [ACC_W:0]  cond_s;
   logic [TEMP_WIDTH-1:0]  cond_sat, cond_ff;
   assign acc_sh = acc_ff >>> 24;
   assign cond_s = $signed({{(ACC_W+1-TEMP_WIDTH){1'b0}}, ctr_temp_ff})
                 + $signed({acc_sh[ACC_W-1], acc_sh});

   always_comb begin
      if (cond_s[ACC_W]) begin
         cond_sat = '0;
      end else if (cond_s > $signed({{(ACC_W+1-TEMP_WIDTH){1'b0}}, TEMP_MAX})) begin
         cond_sat = TEMP_MAX;
      end else begin
         cond_sat = cond_s[TEMP_WIDTH-1:0];
      end
   end

   // radiation product coeff * ti^4, limb by limb with sticky overflow
   logic [31:0] carry_ff;
   logic        ovf_ff;
   logic [63:0] limb_sum;
   assign limb_sum = prod_ff[63:0] + {32'h0, carry_ff};

   always_ff @(posedge clock) begin
      if (cmd.cond_calc) begin
         cond_ff  <= cond_sat;
         ti_ff    <= cond_sat[TEMP_WIDTH-1:8];
         l_ff[0]  <= rad_ff;
         l_ff[1]  <= '0;
         l_ff[2]  <= '0;
         carry_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.add_limb) begin
         l_ff[cmd.limb_sel] <= limb_sum[31:0];
         if (cmd.limb_sel == LIMB_TOP) begin
            ovf_ff   <= ovf_ff | (|limb_sum[63:32]);
            carry_ff <= '0;
         end else begin
            carry_ff <= limb_sum[63:32];
         end
      end
   end

   // final subtraction of the loss
   logic                  big;
   logic [31:0]           loss;
   logic [TEMP_WIDTH-1:0] result;
   assign big  = ovf_ff | (|l_ff[2][31:24]);
   assign loss = {l_ff[2][23:0], l_ff[1][31:24]};
   assign result = (big || ({1'b0, loss} >= 33'(cond_ff))) ? '0
                 : cond_ff - loss[TEMP_WIDTH-1:0];

   // output register
   logic                  rsp_valid_ff;
   logic [TEMP_WIDTH-1:0] rsp_temp_ff;
   logic [RIW-1:0]        rsp_row_ff;
   logic [CIW-1:0]        rsp_col_ff;
   logic                  rsp_fe_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_temp_ff <= result;
         rsp_row_ff  <= flush_ff ? r_ff : r_ff - 1'b1;
         rsp_col_ff  <= j;
         rsp_fe_ff   <= flush_ff && (k_ff == cols_m1);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_temp  = rsp_temp_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_frame_end = rsp_fe_ff;

   // status to the controller
   assign status.has_prev   = (r_ff != '0);
   assign status.is_last    = last_ff;
   assign status.flush_mode = flush_ff;
   assign status.flush_done = (k_ff == cols_m1);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for heat_diffusion_stencil_step: streams grid frames and checks
// every emitted cell against an in-bench prediction of the stencil update.
// Depends on hds_pkg and the block's RTL.
module tb_top import hds_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_LEN   = 400;
   localparam int SETTLE     = 50;

   // expected-cell store plus the block's state and registers
   class stencil_scoreboard;
      typedef struct packed {
         logic [23:0] temp;
         logic        mat;
         logic [15:0] src;
      } cell_t;
      typedef struct packed {
         logic [23:0] temp;
         logic [5:0]  row;
         logic [4:0]  col;
         logic        fe;
      } cell_result_t;

      cell_t        col_mem[2][32];
      int unsigned  row_pos, col_pos;
      logic [6:0]   rows_reg;
      logic [5:0]   cols_reg;
      logic [23:0]  gain_reg, scale_reg;
      logic [31:0]  rad_reg;
      cell_result_t expected_cells[$];
      int           errors, checked;

      function new();
         row_pos = 0; col_pos = 0;
         rows_reg = ROWS_RST; cols_reg = COLS_RST;
         gain_reg = GAIN_RST; scale_reg = SCALE_RST; rad_reg = RAD_RST;
         errors = 0; checked = 0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [31:0] val);
         case (idx)
            REG_ROWS:  rows_reg = val[6:0];
            REG_COLS:  cols_reg = val[5:0];
            REG_GAIN:  gain_reg = val[23:0];
            REG_SCALE: scale_reg = val[23:0];
            REG_RAD:   rad_reg = val;
            default: ;
         endcase
      endfunction

      function int unsigned num_rows();
         return rows_reg < 1 ? 1 : (rows_reg > 64 ? 64 : rows_reg);
      endfunction

      function int unsigned num_cols();
         return cols_reg < 1 ? 1 : (cols_reg > 32 ? 32 : cols_reg);
      endfunction

      function bit at_frame_start();
         return row_pos == 0 && col_pos == 0;
      endfunction

      // one FTCS step plus radiation loss; has = {north, south, west, east} present
      function logic [23:0] diffuse(cell_t c, cell_t n, cell_t s, cell_t w, cell_t e,
                                    logic [3:0] has);
         cell_t        nb[4];
         longint       lap, acc, cond;
         logic [127:0] prod;
         logic [31:0]  loss;
         logic [15:0]  ti;
         nb[0] = n; nb[1] = s; nb[2] = w; nb[3] = e;
         lap = 0;
         for (int i = 0; i < 4; i++)
            lap += (has[3-i] && nb[i].mat) ? longint'(nb[i].temp) : longint'(c.temp);
         lap -= 4 * longint'(c.temp);
         acc = lap * longint'(gain_reg) + longint'(c.src) * longint'(scale_reg) * 256
             + (longint'(1) << 23);
         cond = longint'(c.temp) + (acc >>> 24);
         if (cond < 0) cond = 0;
         if (cond > 24'hFFFFFF) cond = 24'hFFFFFF;
         ti = cond[23:8];
         prod = 128'(ti) * 128'(ti) * 128'(ti) * 128'(ti) * 128'(rad_reg);
         if (prod[127:88] != 0) return '0;
         loss = prod[87:56];
         if (longint'(loss) >= cond) return '0;
         return 24'(cond - longint'(loss));
      endfunction

      // an accepted input beat: compute every cell it releases
      function void note_cell(logic [23:0] t, logic m, logic [15:0] s);
         int unsigned  rows, cols, r, c, cp, pp;
         cell_t        cur;
         cell_result_t res;
         rows = num_rows();
         cols = num_cols();
         r = row_pos < rows ? row_pos : rows - 1;
         c = col_pos < cols ? col_pos : cols - 1;
         cur = '{temp: t, mat: m, src: s};
         cp = r & 1;
         pp = cp ^ 1;
         if (r >= 1) begin
            res.temp = diffuse(col_mem[pp][c], col_mem[cp][c], cur,
                               col_mem[pp][c >= 1 ? c - 1 : c],
                               col_mem[pp][c + 1 < cols ? c + 1 : c],
                               {r >= 2, 1'b1, c >= 1, c + 1 < cols});
            res.row = 6'(r - 1); res.col = 5'(c); res.fe = 1'b0;
            expected_cells.push_back(res);
         end
         col_mem[cp][c] = cur;
         if (r == rows - 1 && c == cols - 1) begin
            // last cell of the frame: flush the final row
            for (int unsigned k = 0; k < cols; k++) begin
               res.temp = diffuse(col_mem[cp][k], col_mem[pp][k], cur,
                                  col_mem[cp][k >= 1 ? k - 1 : k],
                                  col_mem[cp][k + 1 < cols ? k + 1 : k],
                                  {r >= 1, 1'b0, k >= 1, k + 1 < cols});
               res.row = 6'(r); res.col = 5'(k); res.fe = (k == cols - 1);
               expected_cells.push_back(res);
            end
            row_pos = 0; col_pos = 0;
         end else if (c >= cols - 1) begin
            col_pos = 0; row_pos = r + 1;
         end else begin
            col_pos = c + 1; row_pos = r;
         end
      endfunction

      task report_mismatch(string what, longint got, longint want);
         $display("MISMATCH %s: got %0d expected %0d", what, got, want);
         errors++;
      endtask

      // an accepted result beat against the oldest expectation
      task check_cell(logic [23:0] t, logic [5:0] r, logic [4:0] c, logic fe);
         cell_result_t want;
         if (expected_cells.size() == 0) begin
            report_mismatch("unexpected result, row", r, -1);
            return;
         end
         want = expected_cells.pop_front();
         checked++;
         if (t !== want.temp) report_mismatch("new_temp", t, want.temp);
         if (r !== want.row)  report_mismatch("out_row", r, want.row);
         if (c !== want.col)  report_mismatch("out_col", c, want.col);
         if (fe !== want.fe)  report_mismatch("frame_end", fe, want.fe);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [23:0] req_cell_temp = '0;
   logic        req_is_material = 1'b0;
   logic [15:0] req_heat_source = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_new_temp;
   logic [5:0]  rsp_out_row;
   logic [4:0]  rsp_out_col;
   logic        rsp_frame_end;

   stencil_scoreboard sb = new();
   int  cells_sent = 0;
   int  burst_left = 0;
   bit  valid_up = 0;
   bit  hold_req = 0;
   bit  hold_done = 0;
   int  hold_left = 0;
   int  stall_mode = 0;
   int  stall_phase = 0;
   int  idle_cycles = 0;

   heat_diffusion_stencil_step u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cell_temp(req_cell_temp), .req_is_material(req_is_material),
      .req_heat_source(req_heat_source),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_new_temp(rsp_new_temp), .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col), .rsp_frame_end(rsp_frame_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result receiver: stall pattern picked anew when the phase counter wraps, plus one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_LEN;
         hold_done <= 1'b1;
      end else begin
         if (stall_phase == 49) stall_mode <= $urandom_range(0, 2);
         stall_phase <= (stall_phase + 1) % 50;
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_cell(rsp_new_temp, rsp_out_row, rsp_out_col, rsp_frame_end);
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // wait for all expected cells, then let a cell with no result finish
   task drain();
      if (valid_up) begin
         req_valid <= 1'b0;
         valid_up = 0;
      end
      while (sb.expected_cells.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // write all five registers; only called while the block is idle
   task program_regs(logic [6:0] rows, logic [5:0] cols, logic [23:0] gain,
                     logic [23:0] scale, logic [31:0] rad);
      logic [31:0] vals[5];
      vals[REG_ROWS] = rows; vals[REG_COLS] = cols; vals[REG_GAIN] = gain;
      vals[REG_SCALE] = scale; vals[REG_RAD] = rad;
      for (int i = 0; i < 5; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wr_data <= vals[i];
         @(posedge clock);
         sb.set_reg(CSR_IDX_W'(i), vals[i]);
      end
      csr_wr_en <= 1'b0;
   endtask

   // one input beat, then maybe a gap between bursts
   task send_cell(logic [23:0] t, logic m, logic [15:0] s);
      int gap;
      req_cell_temp <= t;
      req_is_material <= m;
      req_heat_source <= s;
      req_valid <= 1'b1;
      valid_up = 1;
      do @(posedge clock); while (!req_ready);
      sb.note_cell(t, m, s);
      cells_sent++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            valid_up = 0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task send_random_cell();
      logic [23:0] t;
      logic [15:0] s;
      t = ($urandom_range(0, 2) == 0) ? 24'($urandom) : 24'($urandom_range(51200, 512000));
      s = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      send_cell(t, $urandom_range(0, 3) != 0, s);
   endtask

   function logic [23:0] pick_gain();
      case ($urandom_range(0, 4))
         0: return 24'd0;
         1: return 24'hFFFFFF;
         2: return 24'($urandom);
         default: return 24'($urandom_range(0, 4000000));
      endcase
   endfunction

   function logic [31:0] pick_rad();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return 32'hFFFFFFFF;
         2: return 32'($urandom);
         3: return RAD_RST;
         default: return 32'($urandom_range(1 << 20, 1 << 30));
      endcase
   endfunction

   initial begin
      int frames;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: 3x3 frame with extreme fields and maximum gains
      program_regs(7'd3, 6'd3, 24'hFFFFFF, 24'hFFFFFF, 32'd0);
      send_cell(24'd0, 1'b1, 16'hFFFF);
      send_cell(24'hFFFFFF, 1'b1, 16'd0);
      send_cell(24'd76800, 1'b0, 16'd100);
      send_cell(24'hFFFFFF, 1'b0, 16'hFFFF);
      send_cell(24'd0, 1'b1, 16'd0);
      send_cell(24'h800000, 1'b1, 16'h8000);
      send_cell(24'h7FFFFF, 1'b1, 16'h7FFF);
      send_cell(24'hAAAAAA, 1'b0, 16'h5555);
      send_cell(24'h555555, 1'b1, 16'hAAAA);
      drain();

      // huge radiation loss, zero gains
      program_regs(7'd2, 6'd2, 24'd0, 24'd0, 32'hFFFFFFFF);
      send_cell(24'hFFFFFF, 1'b1, 16'd0);
      send_cell(24'd25600, 1'b1, 16'd0);
      send_cell(24'd1, 1'b1, 16'd1);
      send_cell(24'hFFFFFF, 1'b1, 16'hFFFF);
      drain();

      // geometry shrinks in the middle of a frame
      program_regs(7'd4, 6'd6, GAIN_RST, SCALE_RST, RAD_RST);
      for (int i = 0; i < 15; i++) send_random_cell();
      drain();
      program_regs(7'd3, 6'd3, GAIN_RST, SCALE_RST, RAD_RST);
      while (!sb.at_frame_start()) send_random_cell();
      drain();

      // out-of-range geometry: single row of saturated width, then single column of saturated height
      program_regs(7'd0, 6'd63, pick_gain(), pick_gain(), pick_rad());
      repeat (32) send_random_cell();
      drain();
      program_regs(7'd127, 6'd0, pick_gain(), pick_gain(), pick_rad());
      repeat (64) send_random_cell();
      drain();

      // random frames; the first carries a long receiver hold
      frames = 0;
      while (cells_sent < 150) begin
         program_regs(7'($urandom_range(1, 6)), 6'($urandom_range(1, 8)),
                      pick_gain(), pick_gain(), pick_rad());
         if (frames == 0) hold_req = 1;
         do send_random_cell(); while (!sb.at_frame_start());
         if ($urandom_range(0, 1) == 0 || frames == 0) drain();
         else begin
            while (sb.expected_cells.size() > 0) begin
               if (valid_up) begin
                  req_valid <= 1'b0;
                  valid_up = 0;
               end
               @(posedge clock);
            end
            repeat (SETTLE) @(posedge clock);
         end
         frames++;
      end

      drain();
      repeat (100) @(posedge clock);
      $display("Streamed %0d cells over %0d random frames plus directed frames;",
               cells_sent, frames);
      $display("checked %0d emitted cells, %0d mismatches.", sb.checked, sb.errors);
      if (sb.errors == 0 && sb.expected_cells.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

@@ filelist.f @@
src/hds_pkg.sv
src/hds_ctrl.sv
src/hds_datapath.sv
src/heat_diffusion_stencil_step.sv
tb/tb_top.sv
